@@ rtl/frame_drop_alert_monitor_core_defines.svh @@
// Assertion helpers shared by the monitor RTL.
`ifndef FRAME_DROP_ALERT_MONITOR_CORE_DEFINES_SVH
`define FRAME_DROP_ALERT_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FDAM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdam: assertion failed");

// Next-cycle implication, checked outside reset.
`define FDAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdam: assertion failed");

`endif

@@ rtl/fdam_pkg.sv @@
`default_nettype none
package fdam_pkg;

  localparam int TICK_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int THRESH_W = 14;
  localparam int PHASE_W  = 17;
  localparam int PROD_W   = COUNT_W + THRESH_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FDAM_QUEUE_DEPTH = 2;

  localparam logic [THRESH_W-1:0] DROP_SCALE = 14'd10000;

  localparam logic [CFG_IDX_W-1:0] CFG_DROP_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDE_AFTER       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_DURATION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_BLINK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_BLINK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_FLAGS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_SELECT   = 3'd6;

  localparam int FLAG_STABLE_EN = 0;
  localparam int FLAG_FORCE     = 1;
  localparam int FLAG_MANUAL    = 2;
  localparam int SEL_ALERT_IMG  = 0;
  localparam int SEL_STABLE_IMG = 1;

  typedef struct packed {
    logic [TICK_W-1:0]  elapsed_ms;
    logic               stream_on;
    logic [COUNT_W-1:0] total_frames;
    logic [COUNT_W-1:0] dropped_frames;
  } in_item_t;

  typedef struct packed {
    logic alert_text_on;
    logic alert_image_on;
    logic stable_text_on;
    logic stable_image_on;
    logic alert_active;
    logic stable_active;
  } result_t;

  typedef struct packed {
    logic [THRESH_W-1:0] drop_threshold;
    logic [TICK_W-1:0]   hide_after_ms;
    logic [TICK_W-1:0]   stable_duration_ms;
    logic [TICK_W-1:0]   alert_blink_period_ms;
    logic [TICK_W-1:0]   stable_blink_period_ms;
    logic [2:0]          control_flags;
    logic [1:0]          content_select;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_FORCE  = 2'd0,
    MODE_IDLE   = 2'd1,
    MODE_STREAM = 2'd2
  } tick_mode_t;

  typedef struct packed {
    logic [TICK_W-1:0]  elapsed_ms;
    tick_mode_t         mode;
    logic [COUNT_W-1:0] d_total;
    logic [COUNT_W-1:0] d_drop;
  } work_t;

endpackage
`default_nettype wire

@@ rtl/frame_drop_alert_monitor_core.sv @@
`default_nettype none
// Frame drop alert monitor. One item per tick (elapsed time, streaming flag, running
// frame and drop counters) gives one result with the four overlay enables and the alert
// and stable states after that tick. The front end forms counter deltas at accept time
// and places work in a small queue; the back end takes one item at a time: it loads it,
// uses its shared 32x14 multiplier twice for the threshold test, updates the state,
// forms the phase remainder of both blink generators bit-serially, then loads the output
// register once it holds no unread result. Up to QUEUE_DEPTH items wait in the queue and
// one finished result in the output register. Registers are written through the always
// ready cfg port, by the user only while no item is in flight; the block does not check.
module frame_drop_alert_monitor_core
  import fdam_pkg::*;
#(
  parameter int QUEUE_DEPTH = FDAM_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_item_t              item,
  output logic                       empty,
  input  wire logic                  pop,
  output result_t                    result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;
  work_t q_wr_data;
  work_t q_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drop_threshold         <= 14'd100;
      cfg.hide_after_ms          <= 16'd3000;
      cfg.stable_duration_ms     <= 16'd3000;
      cfg.alert_blink_period_ms  <= '0;
      cfg.stable_blink_period_ms <= '0;
      cfg.control_flags          <= 3'd1;
      cfg.content_select         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DROP_THRESHOLD:  cfg.drop_threshold         <= cfg_data[THRESH_W-1:0];
        CFG_HIDE_AFTER:      cfg.hide_after_ms          <= cfg_data;
        CFG_STABLE_DURATION: cfg.stable_duration_ms     <= cfg_data;
        CFG_ALERT_BLINK:     cfg.alert_blink_period_ms  <= cfg_data;
        CFG_STABLE_BLINK:    cfg.stable_blink_period_ms <= cfg_data;
        CFG_CONTROL_FLAGS:   cfg.control_flags          <= cfg_data[2:0];
        CFG_CONTENT_SELECT:  cfg.content_select         <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  fdam_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .cfg    (cfg),
    .q_full (full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  fdam_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  fdam_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
`default_nettype wire

@@ rtl/fdam_front.sv @@
`default_nettype none
module fdam_front
  import fdam_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  input  wire logic     q_full,
  output logic          q_push,
  output work_t         q_data
);

  logic [COUNT_W-1:0] last_total;
  logic [COUNT_W-1:0] last_dropped;
  logic               wrapped;

  assign q_push  = push && !q_full;
  assign wrapped = (item.total_frames < last_total) || (item.dropped_frames < last_dropped);

  always_comb begin
    q_data.elapsed_ms = item.elapsed_ms;
    q_data.d_total    = '0;
    q_data.d_drop     = '0;
    if (cfg.control_flags[FLAG_FORCE]) begin
      q_data.mode = MODE_FORCE;
    end else if (!item.stream_on) begin
      q_data.mode = MODE_IDLE;
    end else begin
      q_data.mode = MODE_STREAM;
      if (!wrapped) begin
        q_data.d_total = item.total_frames - last_total;
        q_data.d_drop  = item.dropped_frames - last_dropped;
      end
    end
  end

  // counter baselines
  always_ff @(posedge clk) begin
    if (rst) begin
      last_total   <= '0;
      last_dropped <= '0;
    end else if (q_push && !cfg.control_flags[FLAG_FORCE]) begin
      if (item.stream_on) begin
        last_total   <= item.total_frames;
        last_dropped <= item.dropped_frames;
      end else begin
        last_total   <= '0;
        last_dropped <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fdam_queue.sv @@
`default_nettype none
module fdam_queue
  import fdam_pkg::*;
#(
  parameter int DEPTH = FDAM_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire work_t wr_data,
  output logic       full,
  input  wire logic  rd_en,
  output work_t      rd_data,
  output logic       empty
);

  `include "frame_drop_alert_monitor_core_defines.svh"

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  work_t            mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `FDAM_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CntW'(DEPTH))
  `FDAM_ASSERT_NEXT(a_count_inc, clk, rst, do_wr && !do_rd, count == $past(count) + 1'b1)
  `FDAM_ASSERT_NEXT(a_count_dec, clk, rst, do_rd && !do_wr, count == $past(count) - 1'b1)

endmodule
`default_nettype wire

@@ rtl/fdam_back.sv @@
`default_nettype none
module fdam_back
  import fdam_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_empty,
  input  wire work_t q_data,
  output logic       q_pop,
  output result_t    result,
  output logic       empty,
  input  wire logic  pop
);

  `include "frame_drop_alert_monitor_core_defines.svh"

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL_A = 6'b000010,
    S_MUL_B = 6'b000100,
    S_UPD   = 6'b001000,
    S_MOD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  localparam int CntW = $clog2(PHASE_W);

  state_t              state;
  work_t               work;
  logic [PROD_W-1:0]   prod_drop;
  logic [PROD_W-1:0]   prod_thr;
  logic [COUNT_W-1:0]  mul_a;
  logic [THRESH_W-1:0] mul_b;
  logic [PROD_W-1:0]   mul_p;

  logic                alert_flag;
  logic                stable_flag;
  logic [TICK_W-1:0]   quiet_time;
  logic [TICK_W-1:0]   stable_remaining;
  logic [PHASE_W-1:0]  alert_phase;
  logic [PHASE_W-1:0]  stable_phase;
  logic                alert_blink_lit;
  logic                stable_blink_lit;

  logic                alert_next;
  logic                stable_next;
  logic [TICK_W-1:0]   quiet_next;
  logic [TICK_W-1:0]   remaining_next;
  logic [TICK_W:0]     quiet_sum;
  logic                spiked;

  logic [PHASE_W-1:0]  div_a;
  logic [PHASE_W-1:0]  div_s;
  logic [TICK_W-1:0]   rem_a;
  logic [TICK_W-1:0]   rem_s;
  logic [TICK_W-1:0]   rem_a_next;
  logic [TICK_W-1:0]   rem_s_next;
  logic [CntW-1:0]     bit_cnt;

  logic                out_valid;
  logic                out_load;
  logic                alert_shown;
  logic                stable_shown;

  function automatic logic [TICK_W-1:0] rem_step(input logic [TICK_W-1:0] rem,
                                                  input logic             din,
                                                  input logic [TICK_W-1:0] period);
    logic [TICK_W:0] t;
    logic [TICK_W:0] d;
    t = {rem, din};
    d = t - {1'b0, period};
    rem_step = (t >= {1'b0, period}) ? d[TICK_W-1:0] : t[TICK_W-1:0];
  endfunction

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;

  // shared 32x14 multiplier
  assign mul_a = (state == S_MUL_A) ? work.d_drop : work.d_total;
  assign mul_b = (state == S_MUL_A) ? DROP_SCALE : cfg.drop_threshold;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign spiked    = (work.d_total != '0) && (work.d_drop != '0) && (prod_drop >= prod_thr);
  assign quiet_sum = {1'b0, quiet_time} + {1'b0, work.elapsed_ms};

  always_comb begin
    alert_next     = alert_flag;
    stable_next    = stable_flag;
    quiet_next     = quiet_time;
    remaining_next = stable_remaining;
    case (work.mode)
      MODE_FORCE: begin
        alert_next     = 1'b1;
        quiet_next     = '0;
        stable_next    = 1'b0;
        remaining_next = '0;
      end
      MODE_STREAM: begin
        if (spiked) begin
          alert_next     = 1'b1;
          quiet_next     = '0;
          stable_next    = 1'b0;
          remaining_next = '0;
        end else begin
          quiet_next = quiet_sum[TICK_W] ? '1 : quiet_sum[TICK_W-1:0];
          if (quiet_next >= cfg.hide_after_ms) begin
            alert_next = 1'b0;
          end
        end
        if (cfg.control_flags[FLAG_STABLE_EN]) begin
          if (alert_flag && !alert_next) begin
            stable_next    = 1'b1;
            remaining_next = cfg.stable_duration_ms;
          end
          if (stable_next) begin
            if (work.elapsed_ms >= remaining_next) begin
              stable_next    = 1'b0;
              remaining_next = '0;
            end else begin
              remaining_next = remaining_next - work.elapsed_ms;
            end
          end
        end else begin
          stable_next    = 1'b0;
          remaining_next = '0;
        end
      end
      default: begin
        alert_next     = 1'b0;
        quiet_next     = '0;
        stable_next    = 1'b0;
        remaining_next = '0;
      end
    endcase
  end

  assign rem_a_next = rem_step(rem_a, div_a[bit_cnt], cfg.alert_blink_period_ms);
  assign rem_s_next = rem_step(rem_s, div_s[bit_cnt], cfg.stable_blink_period_ms);

  assign out_load     = (state == S_OUT) && (!out_valid || pop);
  assign alert_shown  = (alert_flag || cfg.control_flags[FLAG_MANUAL]) && alert_blink_lit;
  assign stable_shown = stable_flag && cfg.control_flags[FLAG_STABLE_EN] && stable_blink_lit;

  // sequencer and tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      alert_flag       <= 1'b0;
      stable_flag      <= 1'b0;
      quiet_time       <= '0;
      stable_remaining <= '0;
      alert_phase      <= '0;
      stable_phase     <= '0;
      alert_blink_lit  <= 1'b1;
      stable_blink_lit <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_MUL_A;
          end
        end
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: state <= S_UPD;
        S_UPD: begin
          alert_flag       <= alert_next;
          stable_flag      <= stable_next;
          quiet_time       <= quiet_next;
          stable_remaining <= remaining_next;
          state            <= S_MOD;
        end
        S_MOD: begin
          if (bit_cnt == '0) begin
            if (cfg.alert_blink_period_ms == '0) begin
              alert_phase     <= '0;
              alert_blink_lit <= 1'b1;
            end else begin
              alert_phase     <= {1'b0, rem_a_next};
              alert_blink_lit <= {rem_a_next, 1'b0} < {1'b0, cfg.alert_blink_period_ms};
            end
            if (cfg.stable_blink_period_ms == '0) begin
              stable_phase     <= '0;
              stable_blink_lit <= 1'b1;
            end else begin
              stable_phase     <= {1'b0, rem_s_next};
              stable_blink_lit <= {rem_s_next, 1'b0} < {1'b0, cfg.stable_blink_period_ms};
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_data;
    end
    if (state == S_MUL_A) begin
      prod_drop <= mul_p;
    end
    if (state == S_MUL_B) begin
      prod_thr <= mul_p;
    end
    if (state == S_UPD) begin
      div_a   <= PHASE_W'({1'b0, alert_phase} + (PHASE_W + 1)'(work.elapsed_ms));
      div_s   <= PHASE_W'({1'b0, stable_phase} + (PHASE_W + 1)'(work.elapsed_ms));
      rem_a   <= '0;
      rem_s   <= '0;
      bit_cnt <= CntW'(PHASE_W - 1);
    end
    if (state == S_MOD) begin
      rem_a   <= rem_a_next;
      rem_s   <= rem_s_next;
      bit_cnt <= bit_cnt - 1'b1;
    end
    if (out_load) begin
      result.alert_text_on   <= alert_shown && !cfg.content_select[SEL_ALERT_IMG];
      result.alert_image_on  <= alert_shown && cfg.content_select[SEL_ALERT_IMG];
      result.stable_text_on  <= stable_shown && !cfg.content_select[SEL_STABLE_IMG];
      result.stable_image_on <= stable_shown && cfg.content_select[SEL_STABLE_IMG];
      result.alert_active    <= alert_flag;
      result.stable_active   <= stable_flag;
    end
  end

  `FDAM_ASSERT_NOW(a_alert_stable_excl, clk, rst, 1'b1, !(alert_flag && stable_flag))
  `FDAM_ASSERT_NOW(a_stable_remaining, clk, rst, 1'b1, stable_flag == (stable_remaining != '0))
  `FDAM_ASSERT_NEXT(a_out_fill, clk, rst, (state == S_OUT) && !out_valid, out_valid)

endmodule
`default_nettype wire
